// File: design/c2r_pkg.sv
// Shared types and constants for the convolution layer with bias and ReLU.
// Used by c2r_mac and conv2d_relu_layer; no dependencies.

package c2r_pkg;

  // store geometry
  localparam int MAX_INPUT_SIDE   = 64;
  localparam int MAX_IN_CHANNELS  = 32;
  localparam int MAX_OUT_CHANNELS = 32;
  localparam int MAX_KERNEL       = 11;

  localparam int PIX_PER_CH = MAX_INPUT_SIDE * MAX_INPUT_SIDE;
  localparam int TAPS_PER_K = MAX_KERNEL * MAX_KERNEL;
  localparam int PIX_W      = $clog2(PIX_PER_CH);
  localparam int TAP_W      = $clog2(TAPS_PER_K);
  localparam int CH_W       = $clog2(MAX_IN_CHANNELS);
  localparam int OC_W       = $clog2(MAX_OUT_CHANNELS);
  localparam int FEAT_AW    = CH_W + PIX_W;
  localparam int WGT_AW     = OC_W + CH_W + TAP_W;

  // arithmetic widths
  localparam int SAMPLE_W = 16;
  localparam int PROD_W   = 2 * SAMPLE_W;
  localparam int BIAS_W   = 32;
  localparam int ACC_W    = 48;
  localparam int ACT_W    = 47;
  localparam int Q_SHIFT  = 6;

  // config port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 7;

  // cycles from the last store read until the sum is complete
  localparam int DRAIN_CYCLES = 2;

  typedef enum logic [1:0] {
    ACT_LOAD_PIXEL  = 2'd0,
    ACT_LOAD_WEIGHT = 2'd1,
    ACT_LOAD_BIAS   = 2'd2,
    ACT_COMPUTE     = 2'd3
  } action_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IN_CHANNELS  = 3'd0,
    CFG_OUT_CHANNELS = 3'd1,
    CFG_KERNEL_WIDTH = 3'd2,
    CFG_STRIDE_STEP  = 3'd3,
    CFG_INPUT_SIDE   = 3'd4
  } cfg_index_t;

  // sequencer to multiply-accumulate unit
  typedef struct packed {
    logic clr;
    logic mul_v;
    logic add_v;
  } mac_ctrl_t;

  // multiply-accumulate unit back to sequencer
  typedef struct packed {
    logic busy;
  } mac_stat_t;

endpackage

// File: design/conv2d_relu_layer.sv
// Top level of the convolution layer with bias and ReLU: stores, sequencer,
// config registers and output register. Depends on c2r_pkg and c2r_mac.

// Load requests (pixel, weight, bias) write the stores and leave the sequencer
// idle. A compute request runs in_channels * kernel_width^2 taps (363 taps at
// the reset configuration): one multiply-accumulate per cycle through the
// shared unit, with a registered read of the feature and weight memories in
// front of it, after the setup and check states and before a short drain; an
// invalid position or channel goes from the check state to the output. The
// finished result sits in an output register, so a new request is taken while
// it waits. There is no clearing pass: the stores must be written before they are read.

module conv2d_relu_layer (
  input  logic        clk,
  input  logic        rst,
  // config write port
  input  logic                              cfg_we,
  input  logic [c2r_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [c2r_pkg::CFG_DATA_W-1:0]    cfg_data,
  // request stream
  input  logic        s_tvalid,
  output logic        s_tready,
  // in_channel[4:0], out_channel[9:5], pixel_index[21:10], tap_index[28:22],
  // out_row[34:29], out_col[40:35], value[72:41], zero fill[79:73]
  input  logic [79:0] s_tdata,
  // action[1:0]
  input  logic [1:0]  s_tuser,
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  // activation[46:0], zero fill[47]
  output logic [47:0] m_tdata,
  // out_of_window[0]
  output logic [0:0]  m_tuser
);

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_SETUP  = 7'b0000010,
    ST_CHECK  = 7'b0000100,
    ST_RUN    = 7'b0001000,
    ST_DRAIN  = 7'b0010000,
    ST_BIAS   = 7'b0100000,
    ST_FINISH = 7'b1000000
  } state_t;

  localparam logic [5:0] NIN_MAX  = 6'(c2r_pkg::MAX_IN_CHANNELS);
  localparam logic [5:0] NOUT_MAX = 6'(c2r_pkg::MAX_OUT_CHANNELS);
  localparam logic [3:0] K_MAX    = 4'(c2r_pkg::MAX_KERNEL);
  localparam logic [6:0] SIDE_MAX = 7'(c2r_pkg::MAX_INPUT_SIDE);

  // request fields
  logic [4:0]  in_channel;
  logic [4:0]  out_channel;
  logic [11:0] pixel_index;
  logic [6:0]  tap_index;
  logic [5:0]  out_row;
  logic [5:0]  out_col;
  logic [31:0] value;
  c2r_pkg::action_t action;

  assign in_channel  = s_tdata[4:0];
  assign out_channel = s_tdata[9:5];
  assign pixel_index = s_tdata[21:10];
  assign tap_index   = s_tdata[28:22];
  assign out_row     = s_tdata[34:29];
  assign out_col     = s_tdata[40:35];
  assign value       = s_tdata[72:41];
  assign action      = c2r_pkg::action_t'(s_tuser);

  // config registers
  logic [5:0] in_channels;
  logic [5:0] out_channels;
  logic [3:0] kernel_width;
  logic [3:0] stride_step;
  logic [6:0] input_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_channels  <= 6'd3;
      out_channels <= 6'd32;
      kernel_width <= 4'd11;
      stride_step  <= 4'd4;
      input_side   <= 7'd64;
    end else if (cfg_we) begin
      unique case (cfg_index)
        c2r_pkg::CFG_IN_CHANNELS:  in_channels  <= cfg_data[5:0];
        c2r_pkg::CFG_OUT_CHANNELS: out_channels <= cfg_data[5:0];
        c2r_pkg::CFG_KERNEL_WIDTH: kernel_width <= cfg_data[3:0];
        c2r_pkg::CFG_STRIDE_STEP:  stride_step  <= cfg_data[3:0];
        c2r_pkg::CFG_INPUT_SIDE:   input_side   <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  // saturated working values
  logic [5:0] nin;
  logic [5:0] nout;
  logic [3:0] kw;
  logic [6:0] side;

  assign nin  = (in_channels  > NIN_MAX)  ? NIN_MAX  : in_channels;
  assign nout = (out_channels > NOUT_MAX) ? NOUT_MAX : out_channels;
  assign kw   = (kernel_width > K_MAX)    ? K_MAX    : kernel_width;
  assign side = (input_side   > SIDE_MAX) ? SIDE_MAX : input_side;

  // sequencer registers
  state_t state;
  logic [c2r_pkg::OC_W-1:0]  req_oc;
  logic [5:0]                req_row;
  logic [5:0]                req_col;
  logic [9:0]                r0;
  logic [9:0]                c0;
  logic                      bad;
  logic [c2r_pkg::PIX_W-1:0] base;
  logic [c2r_pkg::PIX_W-1:0] row_start;
  logic [c2r_pkg::CH_W-1:0]  ch;
  logic [3:0]                x;
  logic [3:0]                y;
  logic [c2r_pkg::TAP_W-1:0] tap;
  logic [1:0]                drain;

  logic s_fire;
  logic m_load;
  logic win_ok;
  logic empty_sum;
  logic y_last;
  logic x_last;
  logic ch_last;
  logic [10:0] r_end;
  logic [10:0] c_end;
  logic [16:0] base_prod;
  logic [c2r_pkg::PIX_W-1:0] pix_addr;

  assign s_tready  = (state == ST_IDLE);
  assign s_fire    = s_tvalid && s_tready;
  assign m_load    = (state == ST_FINISH) && (!m_tvalid || m_tready);

  // window bounds
  assign r_end     = {1'b0, r0} + {7'd0, kw};
  assign c_end     = {1'b0, c0} + {7'd0, kw};
  assign win_ok    = ({1'b0, req_oc} < nout) && (r_end <= {4'd0, side}) &&
                     (c_end <= {4'd0, side});
  assign base_prod = r0 * side;
  assign empty_sum = (nin == 6'd0) || (kw == 4'd0);

  // loop ends
  assign y_last   = (y == kw - 4'd1);
  assign x_last   = (x == kw - 4'd1);
  assign ch_last  = ({1'b0, ch} == nin - 6'd1);
  assign pix_addr = row_start + c2r_pkg::PIX_W'(y);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (s_fire && action == c2r_pkg::ACT_COMPUTE) begin
            state <= ST_SETUP;
          end
        end
        ST_SETUP: state <= ST_CHECK;
        ST_CHECK: begin
          if (!win_ok) begin
            state <= ST_FINISH;
          end else if (empty_sum) begin
            state <= ST_BIAS;
          end else begin
            state <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (y_last && x_last && ch_last) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (drain == 2'(c2r_pkg::DRAIN_CYCLES - 1)) begin
            state <= ST_BIAS;
          end
        end
        ST_BIAS: state <= ST_FINISH;
        ST_FINISH: begin
          if (m_load) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // request capture, window origin and loop counters
  always_ff @(posedge clk) begin
    if (s_fire) begin
      req_oc  <= out_channel;
      req_row <= out_row;
      req_col <= out_col;
    end
    if (state == ST_SETUP) begin
      r0 <= req_row * stride_step;
      c0 <= req_col * stride_step;
    end
    if (state == ST_CHECK) begin
      bad       <= !win_ok;
      base      <= c2r_pkg::PIX_W'(base_prod + {7'd0, c0});
      row_start <= c2r_pkg::PIX_W'(base_prod + {7'd0, c0});
      ch        <= '0;
      x         <= '0;
      y         <= '0;
      tap       <= '0;
      drain     <= '0;
    end
    if (state == ST_RUN) begin
      if (!y_last) begin
        y   <= y + 4'd1;
        tap <= tap + c2r_pkg::TAP_W'(1);
      end else if (!x_last) begin
        y         <= '0;
        x         <= x + 4'd1;
        tap       <= tap + c2r_pkg::TAP_W'(1);
        row_start <= row_start + c2r_pkg::PIX_W'(side);
      end else begin
        y         <= '0;
        x         <= '0;
        tap       <= '0;
        row_start <= base;
        ch        <= ch + c2r_pkg::CH_W'(1);
      end
    end
    if (state == ST_DRAIN) begin
      drain <= drain + 2'd1;
    end
  end

  // stores
  logic signed [c2r_pkg::SAMPLE_W-1:0] feature_mem [c2r_pkg::MAX_IN_CHANNELS * c2r_pkg::PIX_PER_CH];
  logic signed [c2r_pkg::SAMPLE_W-1:0] weight_mem  [2 ** c2r_pkg::WGT_AW];
  logic signed [c2r_pkg::BIAS_W-1:0]   bias_mem    [c2r_pkg::MAX_OUT_CHANNELS];

  logic signed [c2r_pkg::SAMPLE_W-1:0] f_q;
  logic signed [c2r_pkg::SAMPLE_W-1:0] w_q;
  logic signed [c2r_pkg::BIAS_W-1:0]   bias_q;
  logic                                rd_v;

  logic feat_we;
  logic wgt_we;
  logic bias_we;

  assign feat_we = s_fire && action == c2r_pkg::ACT_LOAD_PIXEL &&
                   32'(in_channel) < c2r_pkg::MAX_IN_CHANNELS &&
                   32'(pixel_index) < c2r_pkg::PIX_PER_CH;
  assign wgt_we  = s_fire && action == c2r_pkg::ACT_LOAD_WEIGHT &&
                   32'(out_channel) < c2r_pkg::MAX_OUT_CHANNELS &&
                   32'(in_channel) < c2r_pkg::MAX_IN_CHANNELS &&
                   32'(tap_index) < c2r_pkg::TAPS_PER_K;
  assign bias_we = s_fire && action == c2r_pkg::ACT_LOAD_BIAS &&
                   32'(out_channel) < c2r_pkg::MAX_OUT_CHANNELS;

  // memory writes
  always_ff @(posedge clk) begin
    if (feat_we) begin
      feature_mem[{in_channel[c2r_pkg::CH_W-1:0], pixel_index[c2r_pkg::PIX_W-1:0]}]
        <= value[c2r_pkg::SAMPLE_W-1:0];
    end
    if (wgt_we) begin
      weight_mem[{out_channel[c2r_pkg::OC_W-1:0], in_channel[c2r_pkg::CH_W-1:0],
                  tap_index[c2r_pkg::TAP_W-1:0]}] <= value[c2r_pkg::SAMPLE_W-1:0];
    end
    if (bias_we) begin
      bias_mem[out_channel[c2r_pkg::OC_W-1:0]] <= value;
    end
  end

  // registered reads
  always_ff @(posedge clk) begin
    if (state == ST_RUN) begin
      f_q <= feature_mem[{ch, pix_addr}];
      w_q <= weight_mem[{req_oc, ch, tap}];
    end
    if (state == ST_SETUP) begin
      bias_q <= bias_mem[req_oc];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_v <= 1'b0;
    end else begin
      rd_v <= (state == ST_RUN);
    end
  end

  // shared multiply-accumulate unit
  c2r_pkg::mac_ctrl_t              mac_ctrl;
  c2r_pkg::mac_stat_t              mac_stat;
  logic signed [c2r_pkg::ACC_W-1:0] bias_term;
  logic signed [c2r_pkg::ACC_W-1:0] acc;

  assign mac_ctrl.clr   = (state == ST_SETUP);
  assign mac_ctrl.mul_v = rd_v;
  assign mac_ctrl.add_v = (state == ST_BIAS);
  assign bias_term = {{(c2r_pkg::ACC_W - c2r_pkg::BIAS_W - c2r_pkg::Q_SHIFT){bias_q[31]}},
                      bias_q, {c2r_pkg::Q_SHIFT{1'b0}}};

  c2r_mac u_mac (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (mac_ctrl),
    .a      (f_q),
    .b      (w_q),
    .addend (bias_term),
    .acc    (acc),
    .stat   (mac_stat)
  );

  // output register
  logic [c2r_pkg::ACT_W-1:0] act_val;

  assign act_val = (!bad && acc > 0) ? acc[c2r_pkg::ACT_W-1:0] : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (m_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (m_load) begin
      m_tdata <= {1'b0, act_val};
      m_tuser <= bad;
    end
  end

`ifndef ASSERT_OFF
  // bias goes in only once the product pipeline is empty
  a_bias_after_drain: assert property (@(posedge clk) disable iff (rst)
    mac_ctrl.add_v |-> !rd_v && !mac_stat.busy)
    else $error("bias add collides with a pending product");

  // loop counters stay inside the window
  a_loop_bounds: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN) |-> ({1'b0, ch} < nin) && (x < kw) && (y < kw))
    else $error("loop counter outside the window");

  // pixel reads stay inside the configured map
  a_pix_in_map: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN) |-> (14'(pix_addr) < 14'(side * side)))
    else $error("pixel read outside the feature map");

  // an out-of-window result carries zero
  a_flag_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[0]) |-> (m_tdata == '0))
    else $error("flagged result with nonzero activation");

  // a compute request always reaches the setup step next
  a_compute_starts: assert property (@(posedge clk) disable iff (rst)
    (s_fire && action == c2r_pkg::ACT_COMPUTE) |=> (state == ST_SETUP))
    else $error("compute request not started");
`endif

endmodule

// File: design/c2r_mac.sv
// Shared multiply-accumulate unit: one registered 16x16 signed product and
// one accumulator adder that also takes the scaled bias. Depends on c2r_pkg.

module c2r_mac (
  input  logic                                  clk,
  input  logic                                  rst,
  input  c2r_pkg::mac_ctrl_t                    ctrl,
  input  logic signed [c2r_pkg::SAMPLE_W-1:0]   a,
  input  logic signed [c2r_pkg::SAMPLE_W-1:0]   b,
  input  logic signed [c2r_pkg::ACC_W-1:0]      addend,
  output logic signed [c2r_pkg::ACC_W-1:0]      acc,
  output c2r_pkg::mac_stat_t                    stat
);

  logic signed [c2r_pkg::PROD_W-1:0] prod;
  logic                              prod_v;
  logic signed [c2r_pkg::ACC_W-1:0]  operand;

  // product stage
  always_ff @(posedge clk) begin
    if (rst) begin
      prod_v <= 1'b0;
    end else begin
      prod_v <= ctrl.mul_v;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.mul_v) begin
      prod <= a * b;
    end
  end

  // one adder, fed by the product or by the bias term
  assign operand = prod_v ? c2r_pkg::ACC_W'(prod) : addend;

  always_ff @(posedge clk) begin
    if (ctrl.clr) begin
      acc <= '0;
    end else if (prod_v || ctrl.add_v) begin
      acc <= acc + operand;
    end
  end

  assign stat.busy = prod_v;

endmodule
